// ----- rtl/core/complex_fir_filter_macros.svh -----
// Assertion macros shared by the complex FIR filter RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef COMPLEX_FIR_FILTER_MACROS_SVH
`define COMPLEX_FIR_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/cff_pkg.sv -----
// Package of the complex FIR filter: sizes, register indexes, reset values,
// and the command and status structs between controller and datapath. No dependencies.
package cff_pkg;

	localparam int MAX_TAPS     = 32;
	localparam int SAMPLE_BITS  = 16;
	localparam int ACC_BITS     = 40;
	localparam int TAP_BITS     = $clog2(MAX_TAPS);
	localparam int NTAP_BITS    = $clog2(MAX_TAPS + 1);
	localparam int CNT_BITS     = NTAP_BITS;
	localparam int SHIFT_BITS   = 5;
	localparam int PROD_BITS    = 2 * SAMPLE_BITS;
	localparam int SUM_BITS     = PROD_BITS + 1;
	localparam int RND_BITS     = ACC_BITS + 1;
	localparam int IDX_IN_BITS  = 5;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 6;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_TAPS  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_SHIFT = CFG_IDX_BITS'(1);

	localparam logic [NTAP_BITS-1:0]  NUM_TAPS_RST  = NTAP_BITS'(32);
	localparam logic [SHIFT_BITS-1:0] OUT_SHIFT_RST = SHIFT_BITS'(15);

	localparam logic signed [RND_BITS-1:0] SAT_HI = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI - RND_BITS'(1);

	typedef struct packed {
		logic                  shift_in;
		logic                  coef_wr;
		logic                  mac_issue;
		logic                  mac_first;
		logic                  mac_last;
		logic [TAP_BITS-1:0]   x_idx;
		logic [TAP_BITS-1:0]   h_idx;
		logic                  load_out;
		logic                  last_out;
		logic [SHIFT_BITS-1:0] out_shift;
	} cff_cmd_t;

	typedef struct packed {
		logic res_done;
		logic out_free;
	} cff_stat_t;

endpackage

// ----- rtl/core/cff_item_if.sv -----
// Input channel of the complex FIR filter: samples and coefficient loads.
// Depends on cff_pkg for the field widths.
interface cff_item_if;
	import cff_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample_re;
	logic signed [SAMPLE_BITS-1:0] sample_im;
	logic                          block_end;
	logic [IDX_IN_BITS-1:0]        tap_index;
	logic signed [SAMPLE_BITS-1:0] coef_re;
	logic signed [SAMPLE_BITS-1:0] coef_im;

	modport source (
		output valid, kind, sample_re, sample_im, block_end, tap_index, coef_re, coef_im,
		input  ready
	);
	modport sink (
		input  valid, kind, sample_re, sample_im, block_end, tap_index, coef_re, coef_im,
		output ready
	);
endinterface

// ----- rtl/core/cff_result_if.sv -----
// Result channel of the complex FIR filter: one filtered output per transaction.
// Depends on cff_pkg for the field widths.
interface cff_result_if;
	import cff_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_re;
	logic signed [SAMPLE_BITS-1:0] out_im;
	logic                          last_out;
	logic                          saturated;

	modport source (
		output valid, out_re, out_im, last_out, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_re, out_im, last_out, saturated,
		output ready
	);
endinterface

// ----- rtl/core/cff_cfg_if.sv -----
// Configuration write channel of the complex FIR filter.
// Depends on cff_pkg for the index and data widths.
interface cff_cfg_if;
	import cff_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ----- rtl/core/cff_ctrl.sv -----
// Controller of the complex FIR filter: configuration registers, block sample count,
// output scheduling and the tap loop. Depends on cff_pkg.
module cff_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_kind,
	input  logic                             item_block_end,
	output logic                             item_ready,
	input  logic                             cfg_valid,
	input  logic [cff_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [cff_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  cff_pkg::cff_stat_t               stat,
	output cff_pkg::cff_cmd_t                cmd
);
	import cff_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_NEXT    = 5'b00010,
		ST_MAC     = 5'b00100,
		ST_WAIT    = 5'b01000,
		ST_DELIVER = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [NTAP_BITS-1:0]  num_taps_q;
	logic [SHIFT_BITS-1:0] out_shift_q;
	logic                  first_q;
	logic                  end_q;
	logic [TAP_BITS-1:0]   tail_q;
	logic [TAP_BITS-1:0]   d_q;
	logic [TAP_BITS-1:0]   k_q;
	logic [TAP_BITS-1:0]   kmax_q;
	logic                  last_q;

	logic [NTAP_BITS-1:0]  eff_n;
	logic [NTAP_BITS-1:0]  nm1_w;
	logic [TAP_BITS-1:0]   nm1;
	logic [CNT_BITS-1:0]   cnt_new;
	logic [TAP_BITS-1:0]   tail_new;
	logic                  first_new;
	logic [TAP_BITS-1:0]   d_sel;
	logic                  last_sel;
	logic [TAP_BITS-1:0]   kmax_sel;
	logic                  more;
	logic                  item_acc;

	always_comb begin
		if (num_taps_q == '0) begin
			eff_n = NTAP_BITS'(1);
		end else if (num_taps_q > NTAP_BITS'(MAX_TAPS)) begin
			eff_n = NTAP_BITS'(MAX_TAPS);
		end else begin
			eff_n = num_taps_q;
		end
		nm1_w = eff_n - NTAP_BITS'(1);
		nm1   = nm1_w[TAP_BITS-1:0];

		cnt_new   = (cnt_q < CNT_BITS'(MAX_TAPS)) ? cnt_q + CNT_BITS'(1) : cnt_q;
		first_new = (cnt_new >= eff_n);
		// On the final sample the tail flush covers the outputs not yet produced.
		if (item_block_end) begin
			tail_new = (cnt_new < eff_n) ? cnt_new[TAP_BITS-1:0] : nm1;
		end else begin
			tail_new = '0;
		end

		d_sel    = first_q ? nm1 : tail_q - TAP_BITS'(1);
		last_sel = first_q ? (end_q && (tail_q == '0)) : (tail_q == TAP_BITS'(1));
		kmax_sel = (d_sel < nm1) ? d_sel : nm1;
		more     = first_q || (tail_q != '0);
	end

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;

	always_comb begin
		cmd           = '0;
		cmd.out_shift = out_shift_q;
		cmd.shift_in  = item_acc && !item_kind;
		cmd.coef_wr   = item_acc && item_kind;
		cmd.mac_issue = (state_q == ST_MAC);
		cmd.mac_first = (k_q == '0);
		cmd.mac_last  = (k_q == kmax_q);
		cmd.x_idx     = d_q - k_q;
		cmd.h_idx     = nm1 - k_q;
		cmd.load_out  = (state_q == ST_DELIVER) && stat.out_free;
		cmd.last_out  = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q  <= NUM_TAPS_RST;
			out_shift_q <= OUT_SHIFT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_TAPS:  num_taps_q  <= cfg_data[NTAP_BITS-1:0];
				REG_OUT_SHIFT: out_shift_q <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
			end_q   <= 1'b0;
			tail_q  <= '0;
			d_q     <= '0;
			k_q     <= '0;
			kmax_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && !item_kind) begin
						cnt_q   <= item_block_end ? '0 : cnt_new;
						first_q <= first_new;
						tail_q  <= tail_new;
						end_q   <= item_block_end;
						if (first_new || (tail_new != '0)) begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					d_q    <= d_sel;
					last_q <= last_sel;
					kmax_q <= kmax_sel;
					k_q    <= '0;
					if (first_q) begin
						first_q <= 1'b0;
					end else begin
						tail_q <= tail_q - TAP_BITS'(1);
					end
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					k_q <= k_q + TAP_BITS'(1);
					if (k_q == kmax_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (stat.res_done) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (stat.out_free) begin
						state_q <= more ? ST_NEXT : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/cff_dp.sv -----
// Datapath of the complex FIR filter: delay line, tap store, pipelined complex MAC,
// rounding and saturation, and the output register. Depends on cff_pkg.
module cff_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cff_pkg::cff_cmd_t                     cmd,
	output cff_pkg::cff_stat_t                    stat,
	input  logic signed [cff_pkg::SAMPLE_BITS-1:0] sample_re,
	input  logic signed [cff_pkg::SAMPLE_BITS-1:0] sample_im,
	input  logic [cff_pkg::IDX_IN_BITS-1:0]        tap_index,
	input  logic signed [cff_pkg::SAMPLE_BITS-1:0] coef_re,
	input  logic signed [cff_pkg::SAMPLE_BITS-1:0] coef_im,
	input  logic                                  result_ready,
	output logic                                  result_valid,
	output logic signed [cff_pkg::SAMPLE_BITS-1:0] out_re,
	output logic signed [cff_pkg::SAMPLE_BITS-1:0] out_im,
	output logic                                  last_out,
	output logic                                  saturated
);
	import cff_pkg::*;

	logic signed [SAMPLE_BITS-1:0] dl_re [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] dl_im [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] tap_re_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] tap_im_q [MAX_TAPS];

	logic                          vld_s1, first_s1, last_s1;
	logic signed [SAMPLE_BITS-1:0] x_re_s1, x_im_s1, h_re_s1, h_im_s1;
	logic                          vld_s2, first_s2, last_s2;
	logic signed [PROD_BITS-1:0]   p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic                          vld_s3, first_s3, last_s3;
	logic signed [SUM_BITS-1:0]    sum_re_s3, sum_im_s3;
	logic                          done_s4;
	logic signed [ACC_BITS-1:0]    acc_re_s4, acc_im_s4;
	logic                          done_s5;
	logic signed [RND_BITS-1:0]    rnd_re_s5, rnd_im_s5;
	logic                          done_s6;
	logic signed [SAMPLE_BITS-1:0] res_re_s6, res_im_s6;
	logic                          sat_s6;

	logic signed [RND_BITS-1:0]    rnd_w;
	logic signed [RND_BITS-1:0]    sh_re, sh_im;
	logic [SAMPLE_BITS:0]          fin_re, fin_im;
	logic                          out_valid_q;

	// Returns the clipped value with the clip flag on top.
	function automatic logic [SAMPLE_BITS:0] sat_fn(input logic signed [RND_BITS-1:0] v);
		logic [SAMPLE_BITS:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
		end else begin
			r = {1'b0, v[SAMPLE_BITS-1:0]};
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			dl_re[0] <= sample_re;
			dl_im[0] <= sample_im;
			for (int i = 1; i < MAX_TAPS; i++) begin
				dl_re[i] <= dl_re[i-1];
				dl_im[i] <= dl_im[i-1];
			end
		end
	end

	// The tap index field spans exactly the store, so every load lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				tap_re_q[i] <= '0;
				tap_im_q[i] <= '0;
			end
		end else if (cmd.coef_wr) begin
			tap_re_q[tap_index[TAP_BITS-1:0]] <= coef_re;
			tap_im_q[tap_index[TAP_BITS-1:0]] <= coef_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
			done_s5 <= 1'b0;
			done_s6 <= 1'b0;
		end else begin
			vld_s1  <= cmd.mac_issue;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3 && last_s3;
			done_s5 <= done_s4;
			done_s6 <= done_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_re_s1  <= dl_re[cmd.x_idx];
		x_im_s1  <= dl_im[cmd.x_idx];
		h_re_s1  <= tap_re_q[cmd.h_idx];
		h_im_s1  <= tap_im_q[cmd.h_idx];
		first_s1 <= cmd.mac_first;
		last_s1  <= cmd.mac_last;

		p_rr_s2  <= PROD_BITS'(x_re_s1) * PROD_BITS'(h_re_s1);
		p_ii_s2  <= PROD_BITS'(x_im_s1) * PROD_BITS'(h_im_s1);
		p_ri_s2  <= PROD_BITS'(x_re_s1) * PROD_BITS'(h_im_s1);
		p_ir_s2  <= PROD_BITS'(x_im_s1) * PROD_BITS'(h_re_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;

		sum_re_s3 <= SUM_BITS'(p_rr_s2) - SUM_BITS'(p_ii_s2);
		sum_im_s3 <= SUM_BITS'(p_ri_s2) + SUM_BITS'(p_ir_s2);
		first_s3  <= first_s2;
		last_s3   <= last_s2;

		// The accumulator wraps at its own width.
		if (vld_s3) begin
			acc_re_s4 <= first_s3 ? ACC_BITS'(sum_re_s3) : acc_re_s4 + ACC_BITS'(sum_re_s3);
			acc_im_s4 <= first_s3 ? ACC_BITS'(sum_im_s3) : acc_im_s4 + ACC_BITS'(sum_im_s3);
		end

		if (done_s4) begin
			rnd_re_s5 <= RND_BITS'(acc_re_s4) + rnd_w;
			rnd_im_s5 <= RND_BITS'(acc_im_s4) + rnd_w;
		end

		if (done_s5) begin
			res_re_s6 <= fin_re[SAMPLE_BITS-1:0];
			res_im_s6 <= fin_im[SAMPLE_BITS-1:0];
			sat_s6    <= fin_re[SAMPLE_BITS] || fin_im[SAMPLE_BITS];
		end
	end

	// Round half up: add half an output step before the floor shift.
	always_comb begin
		if (cmd.out_shift == '0) begin
			rnd_w = '0;
		end else begin
			rnd_w = RND_BITS'(1) << (cmd.out_shift - SHIFT_BITS'(1));
		end
		sh_re  = rnd_re_s5 >>> cmd.out_shift;
		sh_im  = rnd_im_s5 >>> cmd.out_shift;
		fin_re = sat_fn(sh_re);
		fin_im = sat_fn(sh_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_re    <= res_re_s6;
			out_im    <= res_im_s6;
			last_out  <= cmd.last_out;
			saturated <= sat_s6;
		end
	end

	assign result_valid  = out_valid_q;
	assign stat.res_done = done_s6;
	assign stat.out_free = !out_valid_q || result_ready;

endmodule

// ----- rtl/core/complex_fir_filter.sv -----
// Top level of the complex FIR filter: joins controller and datapath to the channels.
// Depends on cff_pkg, the channel interfaces, cff_ctrl, cff_dp and the assertion macros.
//
// Channel  Direction  Handshake    Payload
// item     in         valid/ready  kind, sample_re, sample_im, block_end, tap_index,
//                                  coef_re, coef_im
// result   out        valid/ready  out_re, out_im, last_out, saturated
// cfg      in         valid/ready  index, data (always ready)
//
// A coefficient load is written to the tap store on acceptance. A sample runs one shared
// complex MAC per tap: each output it causes passes setup, then min(N, d+1) MAC issues,
// then the pipeline and the handoff, so N MAC issues for the usual single output with
// N taps in use. A sample that causes no output leaves the controller idle; a block end
// flushes up to N-1 more outputs.
// Reset is asynchronous and clears control state and the tap store at once.
// A stalled result holds in the output register; the next item is taken as soon as the
// last result of the current one has been loaded there.
`include "complex_fir_filter_macros.svh"

module complex_fir_filter (
	input  logic                clk,
	input  logic                arst_n,
	cff_item_if.sink            item,
	cff_result_if.source        result,
	cff_cfg_if.sink             cfg
);
	import cff_pkg::*;

	cff_cmd_t  cmd;
	cff_stat_t stat;
	logic      item_ready;

	assign item.ready = item_ready;
	assign cfg.ready  = 1'b1;

	cff_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item.valid),
		.item_kind      (item.kind),
		.item_block_end (item.block_end),
		.item_ready     (item_ready),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.stat           (stat),
		.cmd            (cmd)
	);

	cff_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample_re    (item.sample_re),
		.sample_im    (item.sample_im),
		.tap_index    (item.tap_index),
		.coef_re      (item.coef_re),
		.coef_im      (item.coef_im),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.out_re       (result.out_re),
		.out_im       (result.out_im),
		.last_out     (result.last_out),
		.saturated    (result.saturated)
	);

	// The tap loop only runs while no new item can be taken.
	`CFF_ASSERT_SAME(a_mac_busy, clk, arst_n, cmd.mac_issue, !item_ready, "MAC issued while idle")
	// A finished output is never loaded over one that has not been taken.
	`CFF_ASSERT_SAME(a_load_free, clk, arst_n, cmd.load_out, stat.out_free, "output overwritten")
	// A loaded output shows up on the result channel in the next cycle.
	`CFF_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_out, result.valid, "loaded output lost")
	// Pipeline results arrive only while an item is in work.
	`CFF_ASSERT_SAME(a_done_busy, clk, arst_n, stat.res_done, !item_ready, "result while idle")

endmodule

// ----- bench/complex_fir_filter_tb.sv -----
// Self-checking testbench of complex_fir_filter: streams samples and coefficient loads,
// predicts every filtered output from its own filter state and compares each result.
// Depends on cff_pkg, the three channel interfaces and the complex_fir_filter RTL.
module complex_fir_filter_tb;
	import cff_pkg::*;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_COEF    = 1'b1;
	localparam int   DRAIN_CYCLES = 80;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   HOLD_PHASE   = 2;
	localparam int   NUM_PHASES   = 7;

	typedef logic signed [SAMPLE_BITS-1:0] q15_t;

	localparam q15_t Q15_MAX = q15_t'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam q15_t Q15_MIN = -Q15_MAX - q15_t'(1);

	typedef struct {
		logic                   kind;
		q15_t                   sample_re;
		q15_t                   sample_im;
		logic                   block_end;
		logic [IDX_IN_BITS-1:0] tap_index;
		q15_t                   coef_re;
		q15_t                   coef_im;
	} fir_item_t;

	typedef struct {
		q15_t re;
		q15_t im;
		logic last;
		logic sat;
	} fir_out_t;

	// Phase plan: taps register, shift register, sender idle and receiver stall percent,
	// and the number of input items to queue.
	localparam int PH_TAPS[NUM_PHASES]  = '{32, 0, 63, 7, 1, 12, 3};
	localparam int PH_SHIFT[NUM_PHASES] = '{15, 14, 17, 31, 0, 12, 16};
	localparam int PH_SEND[NUM_PHASES]  = '{0, 59, 0, 37, 0, 59, 37};
	localparam int PH_RECV[NUM_PHASES]  = '{0, 0, 59, 37, 0, 0, 37};
	localparam int PH_ITEMS[NUM_PHASES] = '{70, 60, 80, 60, 60, 80, 70};

	logic clk;
	logic arst_n;

	cff_item_if   item_ch();
	cff_result_if result_ch();
	cff_cfg_if    cfg_ch();

	complex_fir_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Filter state mirrored by the predictor.
	q15_t                     line_re [MAX_TAPS];
	q15_t                     line_im [MAX_TAPS];
	q15_t                     tap_re  [MAX_TAPS];
	q15_t                     tap_im  [MAX_TAPS];
	int                       block_fill;
	logic [CFG_DATA_BITS-1:0] taps_reg;
	logic [SHIFT_BITS-1:0]    shift_reg;

	fir_item_t pending_items[$];
	fir_out_t  expected_outputs[$];
	fir_item_t on_bus;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        failures;
	int        phase_id = -1;
	logic      hold_results;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("complex_fir_filter verification failed");
		$finish;
	end

	function automatic void queue_item(input fir_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic void expect_output(input fir_out_t o);
		expected_outputs = {expected_outputs, o};
	endfunction

	function automatic int active_taps();
		if (taps_reg == 0)
			return 1;
		if (taps_reg > MAX_TAPS)
			return MAX_TAPS;
		return int'(taps_reg);
	endfunction

	// Wrap to the accumulator width, shift with round half up, then clip to 16 bits.
	function automatic q15_t round_clip(input longint acc, inout logic clipped);
		logic signed [ACC_BITS-1:0] wrapped;
		longint v;
		wrapped = acc[ACC_BITS-1:0];
		v = wrapped;
		if (shift_reg != 0)
			v += longint'(1) << (shift_reg - 1);
		v = v >>> shift_reg;
		if (v > Q15_MAX) begin
			v = Q15_MAX;
			clipped = 1'b1;
		end
		if (v < Q15_MIN) begin
			v = Q15_MIN;
			clipped = 1'b1;
		end
		return q15_t'(v);
	endfunction

	// Output whose first sample sits at age d in the delay line (age 0 is the newest).
	function automatic fir_out_t tap_sum(input int d, input int n, input logic last);
		longint   acc_re;
		longint   acc_im;
		longint   xr, xm, hr, hm;
		logic     clipped;
		int       k;
		fir_out_t o;
		acc_re = 0;
		acc_im = 0;
		clipped = 1'b0;
		for (k = 0; k < n && k <= d; k++) begin
			xr = line_re[(d - k) % MAX_TAPS];
			xm = line_im[(d - k) % MAX_TAPS];
			hr = tap_re[(n - 1 - k) % MAX_TAPS];
			hm = tap_im[(n - 1 - k) % MAX_TAPS];
			acc_re += xr * hr - xm * hm;
			acc_im += xr * hm + xm * hr;
		end
		o.re = round_clip(acc_re, clipped);
		o.im = round_clip(acc_im, clipped);
		o.last = last;
		o.sat = clipped;
		return o;
	endfunction

	function automatic void filter_item(input fir_item_t it);
		int n, tail, d, i;
		n = active_taps();
		if (it.kind == KIND_COEF) begin
			tap_re[it.tap_index] = it.coef_re;
			tap_im[it.tap_index] = it.coef_im;
			return;
		end
		for (i = MAX_TAPS - 1; i > 0; i--) begin
			line_re[i] = line_re[i-1];
			line_im[i] = line_im[i-1];
		end
		line_re[0] = it.sample_re;
		line_im[0] = it.sample_im;
		if (block_fill < MAX_TAPS)
			block_fill++;
		tail = 0;
		if (it.block_end)
			tail = (block_fill < n - 1) ? block_fill : n - 1;
		if (block_fill >= n)
			expect_output(tap_sum(n - 1, n, it.block_end && tail == 0));
		// The block end flushes the outputs whose windows run past the last sample.
		for (d = tail; d > 0; d--)
			expect_output(tap_sum(d - 1, n, d == 1));
		if (it.block_end)
			block_fill = 0;
	endfunction

	function automatic q15_t rand_q15();
		case ($urandom_range(0, 9))
			0: return Q15_MAX;
			1: return Q15_MIN;
			2, 3: return q15_t'(int'($urandom_range(0, 4095)) - 2048);
			default: return q15_t'($urandom);
		endcase
	endfunction

	function automatic fir_item_t random_fields(input logic kind, input logic block_end);
		fir_item_t it;
		it.kind = kind;
		it.sample_re = rand_q15();
		it.sample_im = rand_q15();
		it.block_end = block_end;
		it.tap_index = IDX_IN_BITS'($urandom_range(0, MAX_TAPS - 1));
		it.coef_re = rand_q15();
		it.coef_im = rand_q15();
		return it;
	endfunction

	function automatic fir_item_t make_item(input logic kind, input int s_re, input int s_im,
			input logic block_end, input int idx, input int c_re, input int c_im);
		fir_item_t it;
		it.kind = kind;
		it.sample_re = q15_t'(s_re);
		it.sample_im = q15_t'(s_im);
		it.block_end = block_end;
		it.tap_index = IDX_IN_BITS'(idx);
		it.coef_re = q15_t'(c_re);
		it.coef_im = q15_t'(c_im);
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_NUM_TAPS)
			taps_reg = value;
		else if (idx == REG_OUT_SHIFT)
			shift_reg = value[SHIFT_BITS-1:0];
	endtask

	// Waits until every queued item has been taken and every output has come back.
	task automatic drain_phase();
		while (pending_items.size() != 0 || item_ch.valid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input driver: the predictor runs on every accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				filter_item(on_bus);
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = pending_items.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.kind <= on_bus.kind;
					item_ch.sample_re <= on_bus.sample_re;
					item_ch.sample_im <= on_bus.sample_im;
					item_ch.block_end <= on_bus.block_end;
					item_ch.tap_index <= on_bus.tap_index;
					item_ch.coef_re <= on_bus.coef_re;
					item_ch.coef_im <= on_bus.coef_im;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall generator.
	always @(posedge clk) begin : result_monitor
		fir_out_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_outputs.size() == 0) begin
					$error("unexpected result: out_re %0d out_im %0d last_out %0b",
						result_ch.out_re, result_ch.out_im, result_ch.last_out);
					failures++;
				end else begin
					want = expected_outputs.pop_front();
					if (result_ch.out_re !== want.re) begin
						$error("out_re mismatch: expected %0d, got %0d", want.re, result_ch.out_re);
						failures++;
					end
					if (result_ch.out_im !== want.im) begin
						$error("out_im mismatch: expected %0d, got %0d", want.im, result_ch.out_im);
						failures++;
					end
					if (result_ch.last_out !== want.last) begin
						$error("last_out mismatch: expected %0b, got %0b", want.last,
							result_ch.last_out);
						failures++;
					end
					if (result_ch.saturated !== want.sat) begin
						$error("saturated mismatch: expected %0b, got %0b", want.sat,
							result_ch.saturated);
						failures++;
					end
				end
			end
			result_ch.ready <= !hold_results && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off while the sender keeps offering, so the filter backs up.
	initial begin
		hold_results = 1'b0;
		wait (phase_id == HOLD_PHASE);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		int i, n, len, s, queued, phase;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_SAMPLE;
		item_ch.sample_re = '0;
		item_ch.sample_im = '0;
		item_ch.block_end = 1'b0;
		item_ch.tap_index = '0;
		item_ch.coef_re = '0;
		item_ch.coef_im = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		failures = 0;
		for (i = 0; i < MAX_TAPS; i++) begin
			line_re[i] = '0;
			line_im[i] = '0;
			tap_re[i] = '0;
			tap_im[i] = '0;
		end
		block_fill = 0;
		taps_reg = CFG_DATA_BITS'(NUM_TAPS_RST);
		shift_reg = OUT_SHIFT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: full-scale taps and samples with no output shift, a block shorter
		// than the filter, a one-sample block, taps rewritten mid-block, and a coefficient
		// load carrying sample fields and a block end that must be ignored.
		write_reg(REG_NUM_TAPS, CFG_DATA_BITS'(4));
		write_reg(REG_OUT_SHIFT, CFG_DATA_BITS'(0));
		queue_item(make_item(KIND_COEF, 0, 0, 1'b0, 0, 32767, -32768));
		queue_item(make_item(KIND_COEF, 0, 0, 1'b0, 1, -32768, -32768));
		queue_item(make_item(KIND_COEF, 0, 0, 1'b0, 2, 1, 0));
		queue_item(make_item(KIND_COEF, 0, 0, 1'b0, 3, -1, 32767));
		queue_item(make_item(KIND_SAMPLE, 32767, 32767, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, -32768, -32768, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 0, 0, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, -32768, 32767, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 1, -1, 1'b1, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 12345, -23456, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, -32768, 32767, 1'b1, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 32767, -32768, 1'b1, 31, -1, -1));
		queue_item(make_item(KIND_SAMPLE, 1000, -1000, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_COEF, -1, -1, 1'b1, 3, 32767, 32767));
		queue_item(make_item(KIND_SAMPLE, -2000, 3000, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 500, 500, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, -32768, -32768, 1'b0, 0, 0, 0));
		queue_item(make_item(KIND_SAMPLE, 7, 7, 1'b1, 0, 0, 0));
		queue_item(make_item(KIND_COEF, 32767, -32768, 1'b1, 31, -32768, 32767));
		drain_phase();

		// Random part: whole blocks of random length with coefficient loads mixed in.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			phase_id = phase;
			write_reg(REG_NUM_TAPS, CFG_DATA_BITS'(PH_TAPS[phase]));
			write_reg(REG_OUT_SHIFT, CFG_DATA_BITS'(PH_SHIFT[phase]));
			send_idle_pct = PH_SEND[phase];
			recv_stall_pct = PH_RECV[phase];
			n = active_taps();
			queued = 0;
			while (queued < PH_ITEMS[phase]) begin
				if ($urandom_range(0, 3) == 0)
					len = $urandom_range(1, n);
				else
					len = $urandom_range(n, 2 * n + 6);
				for (s = 0; s < len; s++) begin
					if ($urandom_range(0, 99) < 12) begin
						queue_item(random_fields(KIND_COEF, 1'($urandom_range(0, 1))));
						if ($urandom_range(0, 9) < 7)
							pending_items[$].tap_index = IDX_IN_BITS'($urandom_range(0, n - 1));
						queued++;
					end
					queue_item(random_fields(KIND_SAMPLE, s == len - 1));
					queued++;
				end
			end
			drain_phase();
		end

		if (failures == 0)
			$display("complex_fir_filter verification clean");
		else
			$display("complex_fir_filter verification failed");
		$finish;
	end

endmodule
